// ----- sv/eatm_pkg.sv -----
package eatm_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int ANGLE_W = 16;
   localparam int WORD_W  = 32;
   localparam int ROT_W   = 34;
   localparam int COL_W   = 2;

   localparam int CORDIC_STEPS = 15;
   localparam int CORDIC_GAIN  = 652032874;
   localparam int CX_W         = 34;
   localparam int CZ_W         = 18;
   localparam int NUM_GROUPS   = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [COL_W-1:0] COL_MOVE = 2'd3;
   localparam logic [COL_W-1:0] COL_LAST_NORMAL = 2'd2;

   typedef enum logic {
      OP_MODEL  = 1'b0,
      OP_NORMAL = 1'b1
   } op_type;

   typedef struct packed {
      op_type                             op;
      logic [2:0][2:0][ROT_W-1:0]         rot;
      logic [2:0][WORD_W-1:0]             inv;
      logic [2:0][WORD_W-1:0]             scale;
      logic [2:0][WORD_W-1:0]             move;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ----- sv/eatm_front.sv -----
module eatm_front #(
   parameter int ANGLE_BITS = eatm_pkg::ANGLE_BITS_DEF,
   parameter int FRAC_BITS  = eatm_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [eatm_pkg::ANGLE_W-1:0]         req_angle_x,
   input  logic [eatm_pkg::ANGLE_W-1:0]         req_angle_y,
   input  logic [eatm_pkg::ANGLE_W-1:0]         req_angle_z,
   input  logic [eatm_pkg::WORD_W-1:0]          req_scale_x,
   input  logic [eatm_pkg::WORD_W-1:0]          req_scale_y,
   input  logic [eatm_pkg::WORD_W-1:0]          req_scale_z,
   input  logic [eatm_pkg::WORD_W-1:0]          req_move_x,
   input  logic [eatm_pkg::WORD_W-1:0]          req_move_y,
   input  logic [eatm_pkg::WORD_W-1:0]          req_move_z,
   input  eatm_pkg::qstat_type                  qstat,
   output logic                                 push_valid,
   output eatm_pkg::entry_type                  push_entry
);
   import eatm_pkg::*;

   localparam int NI  = NUM_GROUPS;
   localparam int QW  = 2 * FRAC_BITS + 1;
   localparam int DPS = (QW + NI - 1) / NI;
   localparam int CPS = (CORDIC_STEPS + NI - 1) / NI;
   localparam int L   = NI + 4;
   localparam int P2  = NI + 3;

   localparam logic signed [CZ_W-1:0] QUARTER  = 18'sd16384;
   localparam logic signed [CZ_W-1:0] HALF     = 18'sd32768;
   localparam logic signed [CX_W:0]   RND_Q15  = 35'sd16384;
   localparam logic signed [CX_W:0]   Q15_MAX  = 35'sd32767;
   localparam logic signed [CX_W:0]   Q15_MIN  = -35'sd32768;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [WORD_W:0] rem;
      logic [QW-1:0]   quo;
   } div_type;

   function automatic logic signed [CZ_W-1:0] atan_bau(input int i);
      case (i)
         0:  return 18'sd8192;
         1:  return 18'sd4836;
         2:  return 18'sd2555;
         3:  return 18'sd1297;
         4:  return 18'sd651;
         5:  return 18'sd326;
         6:  return 18'sd163;
         7:  return 18'sd81;
         8:  return 18'sd41;
         9:  return 18'sd20;
         10: return 18'sd10;
         11: return 18'sd5;
         12: return 18'sd3;
         13: return 18'sd1;
         14: return 18'sd1;
         default: return 18'sd0;
      endcase
   endfunction

   // Map the angle onto the 16-bit circle and fold it into the right half plane.
   function automatic logic [CZ_W:0] fold(input logic [ANGLE_W-1:0] a);
      logic [WORD_W-1:0]      ph;
      logic signed [CZ_W-1:0] z;
      logic                   f;
      ph = {{(WORD_W-ANGLE_W){a[ANGLE_W-1]}}, a} << (WORD_W - ANGLE_BITS);
      z  = CZ_W'($signed(ph[WORD_W-1 -: ANGLE_W]));
      f  = 1'b0;
      if (z > QUARTER) begin
         z = z - HALF;
         f = 1'b1;
      end else if (z < -QUARTER) begin
         z = z + HALF;
         f = 1'b1;
      end
      return {f, z};
   endfunction

   function automatic cordic_type cordic_grp(input cordic_type c, input int g);
      cordic_type             r;
      logic signed [CX_W-1:0] dx;
      logic signed [CX_W-1:0] dy;
      int                     i;
      r = c;
      for (int m = 0; m < CPS; m++) begin
         i = g * CPS + m;
         if (i < CORDIC_STEPS) begin
            dx = r.y >>> i;
            dy = r.x >>> i;
            if (r.z >= 0) begin
               r.x = r.x - dx;
               r.y = r.y + dy;
               r.z = r.z - atan_bau(i);
            end else begin
               r.x = r.x + dx;
               r.y = r.y - dy;
               r.z = r.z + atan_bau(i);
            end
         end
      end
      return r;
   endfunction

   // Long division of 2^(2*FRAC_BITS) by the scale magnitude, DPS quotient bits per stage.
   function automatic div_type div_grp(input div_type d, input logic [WORD_W-1:0] dvs,
                                       input int g);
      div_type r;
      logic    qb;
      int      t;
      r = d;
      for (int m = 0; m < DPS; m++) begin
         t = g * DPS + m;
         if (t < QW) begin
            r.rem = {r.rem[WORD_W-1:0], (t == 0)};
            qb    = 1'b0;
            if (r.rem >= {1'b0, dvs}) begin
               r.rem = r.rem - {1'b0, dvs};
               qb    = 1'b1;
            end
            r.quo = {r.quo[QW-2:0], qb};
         end
      end
      return r;
   endfunction

   function automatic logic signed [15:0] to_q15(input logic signed [CX_W-1:0] v);
      logic signed [CX_W:0] t;
      t = ($signed({v[CX_W-1], v}) + RND_Q15) >>> 15;
      if (t > Q15_MAX) begin
         t = Q15_MAX;
      end else if (t < Q15_MIN) begin
         t = Q15_MIN;
      end
      return t[15:0];
   endfunction

   function automatic logic [WORD_W-1:0] inv_sat(input logic [QW-1:0] q, input logic neg);
      logic [63:0] qe;
      qe = 64'(q);
      if (!neg) begin
         if (qe > 64'h7fff_ffff) return 32'h7fff_ffff;
         return qe[WORD_W-1:0];
      end
      if (qe > 64'h8000_0000) return 32'h8000_0000;
      return -qe[WORD_W-1:0];
   endfunction

   logic [L-1:0]               v_ff;
   logic                       en;

   cordic_type                 cr_ff   [NI+1][3];
   cordic_type                 cr_in   [NI+1][3];
   logic [2:0]                 flip_ff [NI+1];
   logic [2:0]                 flip_in;
   div_type                    dv_ff   [NI+1][3];
   div_type                    dv_in   [NI+1][3];
   logic [2:0][WORD_W-1:0]     dvs_ff  [NI];
   logic [2:0][WORD_W-1:0]     dvs_in;
   op_type                     op_ff   [L];
   logic [2:0][WORD_W-1:0]     scale_ff[L];
   logic [2:0][WORD_W-1:0]     move_ff [L];
   logic [2:0][WORD_W-1:0]     req_scale;
   logic [ANGLE_W-1:0]         req_angle [3];

   logic signed [15:0]         s_ff [3];
   logic signed [15:0]         c_ff [3];
   logic [2:0][WORD_W-1:0]     inv_sc_ff, inv_p1_ff, inv_p2_ff;

   logic signed [31:0] c1c3_ff, c2s3_ff, c3s1_ff, c1s3_ff, c2c3_ff;
   logic signed [31:0] s1s3_ff, c2s1_ff, c1c2_ff, s1s2_ff, c1s2_ff;
   logic signed [15:0] s2_ff, s3_ff, c3_ff;

   logic [2:0][2:0][ROT_W-1:0] rot_ff, rot_in;
   logic signed [47:0]         m_sss, m_css, m_ssc, m_csc;

   assign en         = !(v_ff[L-1] && qstat.full);
   assign req_stall  = !en;
   assign push_valid = v_ff[L-1] && !qstat.full;

   assign req_scale = {req_scale_z, req_scale_y, req_scale_x};
   // Lane 0 is the Y angle, lane 1 X and lane 2 Z, following the Y-X-Z order.
   assign req_angle[0] = req_angle_y;
   assign req_angle[1] = req_angle_x;
   assign req_angle[2] = req_angle_z;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         {flip_in[l], cr_in[0][l].z} = fold(req_angle[l]);
         cr_in[0][l].x = CX_W'(CORDIC_GAIN);
         cr_in[0][l].y = '0;
         dv_in[0][l]   = '0;
         dvs_in[l]     = req_scale[l][WORD_W-1] ? -req_scale[l] : req_scale[l];
      end
      for (int k = 1; k <= NI; k++) begin
         for (int l = 0; l < 3; l++) begin
            cr_in[k][l] = cordic_grp(cr_ff[k-1][l], k - 1);
            dv_in[k][l] = div_grp(dv_ff[k-1][l], dvs_ff[k-1][l], k - 1);
         end
      end
   end

   always_comb begin
      m_sss = 48'(s1s2_ff) * 48'(s3_ff);
      m_css = 48'(c1s2_ff) * 48'(s3_ff);
      m_ssc = 48'(s1s2_ff) * 48'(c3_ff);
      m_csc = 48'(c1s2_ff) * 48'(c3_ff);
      rot_in[0][0] = ROT_W'(c1c3_ff) + ROT_W'(m_sss >>> 15);
      rot_in[0][1] = ROT_W'(c2s3_ff);
      rot_in[0][2] = ROT_W'(m_css >>> 15) - ROT_W'(c3s1_ff);
      rot_in[1][0] = ROT_W'(m_ssc >>> 15) - ROT_W'(c1s3_ff);
      rot_in[1][1] = ROT_W'(c2c3_ff);
      rot_in[1][2] = ROT_W'(m_csc >>> 15) + ROT_W'(s1s3_ff);
      rot_in[2][0] = ROT_W'(c2s1_ff);
      rot_in[2][1] = -(ROT_W'(s2_ff) <<< 15);
      rot_in[2][2] = ROT_W'(c1c2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[L-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff[0]    <= op_type'(req_operation);
         scale_ff[0] <= req_scale;
         move_ff[0]  <= {req_move_z, req_move_y, req_move_x};
         flip_ff[0]  <= flip_in;
         dvs_ff[0]   <= dvs_in;
         for (int l = 0; l < 3; l++) begin
            cr_ff[0][l] <= cr_in[0][l];
            dv_ff[0][l] <= dv_in[0][l];
         end
         for (int k = 1; k < L; k++) begin
            op_ff[k]    <= op_ff[k-1];
            scale_ff[k] <= scale_ff[k-1];
            move_ff[k]  <= move_ff[k-1];
         end
         for (int k = 1; k <= NI; k++) begin
            flip_ff[k] <= flip_ff[k-1];
            for (int l = 0; l < 3; l++) begin
               cr_ff[k][l] <= cr_in[k][l];
               dv_ff[k][l] <= dv_in[k][l];
            end
         end
         for (int k = 1; k < NI; k++) begin
            dvs_ff[k] <= dvs_ff[k-1];
         end

         for (int l = 0; l < 3; l++) begin
            c_ff[l] <= to_q15(flip_ff[NI][l] ? -cr_ff[NI][l].x : cr_ff[NI][l].x);
            s_ff[l] <= to_q15(flip_ff[NI][l] ? -cr_ff[NI][l].y : cr_ff[NI][l].y);
            inv_sc_ff[l] <= inv_sat(dv_ff[NI][l].quo, scale_ff[NI][l][WORD_W-1]);
         end

         c1c3_ff   <= 32'(c_ff[0]) * 32'(c_ff[2]);
         c2s3_ff   <= 32'(c_ff[1]) * 32'(s_ff[2]);
         c3s1_ff   <= 32'(c_ff[2]) * 32'(s_ff[0]);
         c1s3_ff   <= 32'(c_ff[0]) * 32'(s_ff[2]);
         c2c3_ff   <= 32'(c_ff[1]) * 32'(c_ff[2]);
         s1s3_ff   <= 32'(s_ff[0]) * 32'(s_ff[2]);
         c2s1_ff   <= 32'(c_ff[1]) * 32'(s_ff[0]);
         c1c2_ff   <= 32'(c_ff[0]) * 32'(c_ff[1]);
         s1s2_ff   <= 32'(s_ff[0]) * 32'(s_ff[1]);
         c1s2_ff   <= 32'(c_ff[0]) * 32'(s_ff[1]);
         s2_ff     <= s_ff[1];
         s3_ff     <= s_ff[2];
         c3_ff     <= c_ff[2];
         inv_p1_ff <= inv_sc_ff;

         rot_ff    <= rot_in;
         inv_p2_ff <= inv_p1_ff;
      end
   end

   always_comb begin
      push_entry.op    = op_ff[P2];
      push_entry.rot   = rot_ff;
      push_entry.inv   = inv_p2_ff;
      push_entry.scale = scale_ff[P2];
      push_entry.move  = move_ff[P2];
   end

endmodule

// ----- sv/eatm_queue.sv -----
module eatm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  eatm_pkg::entry_type push_entry,
   input  logic                pop,
   output eatm_pkg::entry_type head,
   output eatm_pkg::qstat_type qstat
);
   import eatm_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   cnt_ff;

   assign head        = mem_ff[rd_ff];
   assign qstat.full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign qstat.empty = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_valid) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push_valid && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push_valid) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- sv/eatm_back.sv -----
module eatm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  eatm_pkg::entry_type           head,
   input  eatm_pkg::qstat_type           qstat,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [eatm_pkg::COL_W-1:0]    rsp_column,
   output logic [eatm_pkg::WORD_W-1:0]   rsp_row_zero,
   output logic [eatm_pkg::WORD_W-1:0]   rsp_row_one,
   output logic [eatm_pkg::WORD_W-1:0]   rsp_row_two,
   output logic                          rsp_last,
   output logic                          rsp_zero_scale
);
   import eatm_pkg::*;

   localparam logic signed [65:0] RND_Q30 = 66'sd536870912;
   localparam logic signed [65:0] W_MAX   = 66'sd2147483647;
   localparam logic signed [65:0] W_MIN   = -66'sd2147483648;

   function automatic logic [WORD_W-1:0] round_sat(input logic signed [65:0] p);
      logic signed [65:0] t;
      t = (p + RND_Q30) >>> 30;
      if (t > W_MAX) return 32'h7fff_ffff;
      if (t < W_MIN) return 32'h8000_0000;
      return t[WORD_W-1:0];
   endfunction

   logic                   en;
   logic                   issue;
   logic                   col_last;
   logic [COL_W-1:0]       col_ff;
   logic [1:0]             sel;
   logic [WORD_W-1:0]      k;

   logic                   b_v_ff;
   logic [COL_W-1:0]       b_col_ff;
   logic                   b_last_ff, b_zero_ff, b_move_ff;
   logic signed [65:0]     b_prod_ff [3];
   logic [2:0]             b_pos_ff, b_neg_ff;
   logic [2:0][WORD_W-1:0] b_mv_ff;
   logic [2:0][WORD_W-1:0] res;

   assign en       = !rsp_valid || !rsp_stall;
   assign issue    = en && !qstat.empty;
   assign col_last = (head.op == OP_NORMAL) ? (col_ff == COL_LAST_NORMAL)
                                            : (col_ff == COL_MOVE);
   assign pop      = issue && col_last;
   assign sel      = (col_ff == COL_MOVE) ? 2'd0 : col_ff;
   assign k        = (head.op == OP_NORMAL) ? head.inv[sel] : head.scale[sel];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (b_move_ff) begin
            res[r] = b_mv_ff[r];
         end else if (b_zero_ff) begin
            res[r] = b_pos_ff[r] ? 32'h7fff_ffff : (b_neg_ff[r] ? 32'h8000_0000 : '0);
         end else begin
            res[r] = round_sat(b_prod_ff[r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         b_v_ff    <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (en) begin
         b_v_ff    <= issue;
         rsp_valid <= b_v_ff;
         if (issue) begin
            col_ff <= col_last ? '0 : col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_col_ff  <= col_ff;
         b_last_ff <= col_last;
         b_move_ff <= (col_ff == COL_MOVE);
         b_zero_ff <= (head.op == OP_NORMAL) && (head.scale[sel] == '0);
         b_mv_ff   <= head.move;
         for (int r = 0; r < 3; r++) begin
            b_prod_ff[r] <= 66'($signed(head.rot[sel][r])) * 66'($signed(k));
            b_pos_ff[r]  <= !head.rot[sel][r][ROT_W-1] && (head.rot[sel][r] != '0);
            b_neg_ff[r]  <= head.rot[sel][r][ROT_W-1];
         end
         rsp_column     <= b_col_ff;
         rsp_last       <= b_last_ff;
         rsp_zero_scale <= b_zero_ff;
         rsp_row_zero   <= res[0];
         rsp_row_one    <= res[1];
         rsp_row_two    <= res[2];
      end
   end

endmodule

// ----- sv/euler_affine_transform_matrix.sv -----
// Builds the Y-X-Z Euler model matrix Translate*Ry*Rx*Rz*Scale (operation 0, four
// column words, translation last) or the inverse-scale normal matrix (operation 1,
// three column words) from each request word. The front end is a 12-stage pipeline
// (CORDIC sine/cosine and the 2^(2*FRAC_BITS)/scale divider spread over eight
// stages, then rounding, pair products and the rotation terms) that takes a new
// word every cycle unless a finished word waits on a full queue; a four-entry queue
// feeds the back end, which produces one column per cycle while the output is not
// stalled, through a 34x32 multiplier per row and a rounding stage. The first column
// passes the front end, the queue, then the back end's product and output registers.
module euler_affine_transform_matrix #(
   parameter int ANGLE_BITS = eatm_pkg::ANGLE_BITS_DEF,
   parameter int FRAC_BITS  = eatm_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [eatm_pkg::ANGLE_W-1:0]  req_angle_x,
   input  logic [eatm_pkg::ANGLE_W-1:0]  req_angle_y,
   input  logic [eatm_pkg::ANGLE_W-1:0]  req_angle_z,
   input  logic [eatm_pkg::WORD_W-1:0]   req_scale_x,
   input  logic [eatm_pkg::WORD_W-1:0]   req_scale_y,
   input  logic [eatm_pkg::WORD_W-1:0]   req_scale_z,
   input  logic [eatm_pkg::WORD_W-1:0]   req_move_x,
   input  logic [eatm_pkg::WORD_W-1:0]   req_move_y,
   input  logic [eatm_pkg::WORD_W-1:0]   req_move_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [eatm_pkg::COL_W-1:0]    rsp_column,
   output logic [eatm_pkg::WORD_W-1:0]   rsp_row_zero,
   output logic [eatm_pkg::WORD_W-1:0]   rsp_row_one,
   output logic [eatm_pkg::WORD_W-1:0]   rsp_row_two,
   output logic                          rsp_last,
   output logic                          rsp_zero_scale
);
   import eatm_pkg::*;

   qstat_type qstat;
   entry_type push_entry, head;
   logic      push_valid, pop;

   eatm_front #(
      .ANGLE_BITS (ANGLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_angle_x   (req_angle_x),
      .req_angle_y   (req_angle_y),
      .req_angle_z   (req_angle_z),
      .req_scale_x   (req_scale_x),
      .req_scale_y   (req_scale_y),
      .req_scale_z   (req_scale_z),
      .req_move_x    (req_move_x),
      .req_move_y    (req_move_y),
      .req_move_z    (req_move_z),
      .qstat         (qstat),
      .push_valid    (push_valid),
      .push_entry    (push_entry)
   );

   eatm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   eatm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_column     (rsp_column),
      .rsp_row_zero   (rsp_row_zero),
      .rsp_row_one    (rsp_row_one),
      .rsp_row_two    (rsp_row_two),
      .rsp_last       (rsp_last),
      .rsp_zero_scale (rsp_zero_scale)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !qstat.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("queue read while empty");

   a_move_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_column == COL_MOVE |-> rsp_last && !rsp_zero_scale)
      else $error("translation column must close the matrix");

endmodule

// ----- tb/euler_affine_transform_matrix_tb.sv -----
module euler_affine_transform_matrix_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import eatm_pkg::*;

   typedef struct {
      op_type           op;
      logic signed [15:0] ang_x, ang_y, ang_z;
      logic signed [31:0] scl [3];
      logic signed [31:0] mov [3];
   } xform_type;

   typedef struct {
      logic [1:0]  column;
      logic [31:0] row [3];
      logic        last;
      logic        zero_scale;
   } column_type;

   class matrix_scoreboard;
      column_type columns_due[$];
      int         errors;
      int         checked;
      longint     atan_tab [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                                    5, 3, 1, 1};

      function longint sat_word(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint to_q15(longint v);
         longint r;
         r = (v + 16384) >>> 15;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return r;
      endfunction

      // Rotation mode CORDIC on Q2.30, with a half-turn fold outside +-pi/2.
      function void sine_cosine(logic signed [15:0] ang, output longint s, output longint c);
         longint x, y, z, dx, dy;
         bit flip;
         z = ang;
         flip = 0;
         if (z > 16384) begin
            z -= 32768;
            flip = 1;
         end else if (z < -16384) begin
            z += 32768;
            flip = 1;
         end
         x = CORDIC_GAIN;
         y = 0;
         for (int i = 0; i < 15; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= atan_tab[i];
            end else begin
               x += dx;
               y -= dy;
               z += atan_tab[i];
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         c = to_q15(x);
         s = to_q15(y);
      endfunction

      function longint triple(longint a, longint b, longint c);
         return (a * b * c) >>> 15;
      endfunction

      function longint scaled(longint r, longint k);
         return sat_word((r * k + (64'sd1 <<< 29)) >>> 30);
      endfunction

      function void note(xform_type w);
         longint s1, c1, s2, c2, s3, c3, inv, sc;
         longint rot [3][3];
         longint v [3];
         column_type cw;
         int n;
         sine_cosine(w.ang_y, s1, c1);
         sine_cosine(w.ang_x, s2, c2);
         sine_cosine(w.ang_z, s3, c3);
         rot[0][0] = c1 * c3 + triple(s1, s2, s3);
         rot[0][1] = c2 * s3;
         rot[0][2] = triple(c1, s2, s3) - c3 * s1;
         rot[1][0] = triple(c3, s1, s2) - c1 * s3;
         rot[1][1] = c2 * c3;
         rot[1][2] = triple(c1, c3, s2) + s1 * s3;
         rot[2][0] = c2 * s1;
         rot[2][1] = -(s2 * 32768);
         rot[2][2] = c1 * c2;
         n = (w.op == OP_NORMAL) ? 3 : 4;
         for (int j = 0; j < n; j++) begin
            cw.zero_scale = 0;
            sc = w.scl[j % 3];
            if (j == 3) begin
               for (int r = 0; r < 3; r++) v[r] = w.mov[r];
            end else if (w.op == OP_MODEL) begin
               for (int r = 0; r < 3; r++) v[r] = scaled(rot[j][r], sc);
            end else if (sc == 0) begin
               cw.zero_scale = 1;
               for (int r = 0; r < 3; r++)
                  v[r] = rot[j][r] > 0 ? 64'sd2147483647 :
                         (rot[j][r] < 0 ? -64'sd2147483648 : 64'sd0);
            end else begin
               inv = sat_word((64'sd1 <<< 32) / sc);
               for (int r = 0; r < 3; r++) v[r] = scaled(rot[j][r], inv);
            end
            cw.column = j[1:0];
            for (int r = 0; r < 3; r++) cw.row[r] = v[r][31:0];
            cw.last = (j == n - 1);
            columns_due.push_back(cw);
         end
      endfunction

      function void check(column_type got);
         column_type want;
         checked++;
         if (columns_due.size() == 0) begin
            $display("%0t: unexpected column word %0d", $time, got.column);
            errors++;
            return;
         end
         want = columns_due.pop_front();
         if (got.column !== want.column) begin
            $display("%0t: column expected %0d actual %0d", $time, want.column, got.column);
            errors++;
         end
         for (int r = 0; r < 3; r++)
            if (got.row[r] !== want.row[r]) begin
               $display("%0t: col %0d row %0d expected %h actual %h", $time, want.column, r,
                        want.row[r], got.row[r]);
               errors++;
            end
         if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            errors++;
         end
         if (got.zero_scale !== want.zero_scale) begin
            $display("%0t: zero_scale expected %b actual %b", $time, want.zero_scale,
                     got.zero_scale);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, req_operation = 0;
   logic [15:0] req_angle_x = 0, req_angle_y = 0, req_angle_z = 0;
   logic [31:0] req_scale_x = 0, req_scale_y = 0, req_scale_z = 0;
   logic [31:0] req_move_x = 0, req_move_y = 0, req_move_z = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [1:0] rsp_column;
   logic [31:0] rsp_row_zero, rsp_row_one, rsp_row_two;
   logic rsp_last, rsp_zero_scale;

   matrix_scoreboard sb = new();
   bit calm = 0;          // no idling in the closing part
   bit hold_request = 0;  // asks the receiver for one long hold-off
   int words_sent = 0;

   euler_affine_transform_matrix u_top (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      xform_type w;
      column_type cw;
      if (!reset && req_valid && !req_stall) begin
         w.op = op_type'(req_operation);
         w.ang_x = req_angle_x;
         w.ang_y = req_angle_y;
         w.ang_z = req_angle_z;
         w.scl = '{req_scale_x, req_scale_y, req_scale_z};
         w.mov = '{req_move_x, req_move_y, req_move_z};
         sb.note(w);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         cw.column = rsp_column;
         cw.row = '{rsp_row_zero, rsp_row_one, rsp_row_two};
         cw.last = rsp_last;
         cw.zero_scale = rsp_zero_scale;
         sb.check(cw);
      end
   end

   // Receiver: random stall bursts, plus one long counted hold-off on request.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_stall = 1;
            for (n = 0; n < 80; n++) @(negedge clock);
            rsp_stall = 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge clock);
            rsp_stall = 0;
         end else begin
            rsp_stall = 0;
         end
      end
   end

   task automatic send_word(xform_type w);
      @(negedge clock);
      req_valid = 1;
      req_operation = w.op;
      req_angle_x = w.ang_x;
      req_angle_y = w.ang_y;
      req_angle_z = w.ang_z;
      {req_scale_x, req_scale_y, req_scale_z} = {w.scl[0], w.scl[1], w.scl[2]};
      {req_move_x, req_move_y, req_move_z} = {w.mov[0], w.mov[1], w.mov[2]};
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (!calm && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid = 0;
         repeat ($urandom_range(1, 12) - 1) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return $urandom_range(0, 1) ? 32'h1 : 32'hFFFF_FFFF;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3, 4: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
         default: return $urandom;
      endcase
   endfunction

   function automatic xform_type make_word(op_type op, int ax, int ay, int az,
                                           logic [31:0] s, logic [31:0] m);
      xform_type w;
      w.op = op;
      w.ang_x = 16'(ax);
      w.ang_y = 16'(ay);
      w.ang_z = 16'(az);
      w.scl = '{s, s, s};
      w.mov = '{m, ~m, m};
      return w;
   endfunction

   initial begin
      xform_type w;
      int angs [8] = '{0, 32767, -32768, 16384, -16384, 16385, -16385, 8192};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      for (int i = 0; i < 8; i++)
         send_word(make_word(op_type'(i & 1), angs[i], angs[(i + 3) % 8], angs[(i + 5) % 8],
                             32'h0001_0000, 32'h7FFF_FFFF));
      send_word(make_word(OP_NORMAL, 1000, -2000, 3000, 32'h0, 32'h8000_0000));
      send_word(make_word(OP_NORMAL, 16384, 0, -16384, 32'h0, 32'h0));
      send_word(make_word(OP_NORMAL, 5000, 6000, 7000, 32'h1, 32'h1));
      send_word(make_word(OP_NORMAL, -5000, 6000, -7000, 32'hFFFF_FFFF, 32'h1));
      send_word(make_word(OP_MODEL, 12000, -12000, 3000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_word(make_word(OP_MODEL, 32767, 32767, 32767, 32'h8000_0000, 32'h8000_0000));
      send_word(make_word(OP_NORMAL, -32768, -32768, -32768, 32'h7FFF_FFFF, 32'h0));
      send_word(make_word(OP_NORMAL, 0, 0, 0, 32'h8000_0000, 32'h0));
      send_word(make_word(OP_MODEL, 0, 0, 0, 32'h0, 32'h1234_5678));

      for (int i = 0; i < 200; i++) begin
         if (i == 60) hold_request = 1;
         if (i == 120) begin
            @(negedge clock);
            req_valid = 0;
            while (sb.columns_due.size() != 0) @(posedge clock);
         end
         if (i == 170) calm = 1;
         w.op = op_type'($urandom_range(0, 1));
         w.ang_x = 16'($urandom);
         w.ang_y = 16'($urandom);
         w.ang_z = 16'($urandom);
         for (int k = 0; k < 3; k++) begin
            w.scl[k] = pick_scale();
            w.mov[k] = $urandom;
         end
         send_word(w);
      end
      @(negedge clock);
      req_valid = 0;

      while (sb.columns_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d transform words in both modes and checked %0d column words,",
               words_sent, sb.checked);
      $display("including zero, tiny and extreme scales and long output stalls.");
      if (sb.errors == 0 && sb.columns_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
